>>> hdl/prgb_pkg.sv
// Shared types, codes and constant tables for the palette / RGB565 to RGBA8888 converter.
// Depends on nothing; the interfaces and the top level import it.
package prgb_pkg;

  localparam int DEF_PALETTE_SLOTS   = 32;
  localparam int DEF_PALETTE_ENTRIES = 256;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_INDEXED = 2'd1,
    KIND_DIRECT  = 2'd2
  } kind_t;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0] ALPHA_CLEAR  = 8'd0;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  palette_select;
    logic [7:0]  pixel_index;
    logic [15:0] color_word;
  } pix_beat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_beat_t;

  typedef logic [31:0][7:0] exp5_tab_t;
  typedef logic [63:0][7:0] exp6_tab_t;

  // Channel expansion v*255/max with truncation, worked out at elaboration.
  function automatic exp5_tab_t build_exp5();
    exp5_tab_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = 8'((i * 255) / 31);
    end
    return t;
  endfunction

  function automatic exp6_tab_t build_exp6();
    exp6_tab_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = 8'((i * 255) / 63);
    end
    return t;
  endfunction

  localparam exp5_tab_t EXP5_TAB = build_exp5();
  localparam exp6_tab_t EXP6_TAB = build_exp6();

endpackage

>>> hdl/prgb_ifs.sv
// Valid/ready channel interfaces for the converter: pixel items in, RGBA results out.
// Depends on prgb_pkg for the beat structs.
interface prgb_pix_if;
  import prgb_pkg::*;
  logic      valid;
  logic      ready;
  pix_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface prgb_rgba_if;
  import prgb_pkg::*;
  logic       valid;
  logic       ready;
  rgba_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/palette_and_rgb565_to_rgba8888.sv
// Top level of the palette / RGB565 to RGBA8888 converter.
// Depends on prgb_pkg, the interfaces in prgb_ifs.sv and the prgb_ram memory.
//
// Usage:
//   pixels: one beat per item. A palette write stores color_word at entry
//   pixel_index of palette palette_select and gives no result. An indexed pixel
//   looks up that entry (entry 0 when the entry holds zero) and gives one RGBA
//   beat. A direct pixel expands its RGB565 word and gives one RGBA beat.
//   Unused kinds give nothing, nor do writes or indexed pixels out of range.
//   rgba: one beat per indexed or direct pixel, in order.
//   cfg_we / cfg_wdata: writes the color-key mask, one bit per palette.
//   Each result passes through the read stage and the output register before
//   rgba.valid rises. Throughput is one item per cycle while rgba is not
//   stalled: the palette RAM and a copy of every entry 0 are read in the same
//   cycle, so the fallback needs no second read.
//   Reset clears the pipeline valids and the mask; palette contents are
//   undefined until written, and no clearing pass runs.
//   When rgba stalls, the result holds in the output register, one more item
//   waits in the read stage, and pixels.ready then drops.
module palette_and_rgb565_to_rgba8888 #(
  parameter int PALETTE_SLOTS   = prgb_pkg::DEF_PALETTE_SLOTS,
  parameter int PALETTE_ENTRIES = prgb_pkg::DEF_PALETTE_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  prgb_pix_if.sink          pixels,
  prgb_rgba_if.source       rgba,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata
);
  import prgb_pkg::*;

  localparam int DEPTH  = PALETTE_SLOTS * PALETTE_ENTRIES;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOT_W = (PALETTE_SLOTS > 1) ? $clog2(PALETTE_SLOTS) : 1;

  logic [31:0] colorkey_mask;

  logic        accept;
  logic        in_range;
  logic        is_write;
  logic        is_indexed;
  logic        is_direct;
  logic        has_result;
  logic        ent_we;
  logic        base_we;
  logic        rd_en;
  logic [AW-1:0]     ent_addr;
  logic [SLOT_W-1:0] slot_addr;
  logic [15:0] ent_rdata;
  logic [15:0] base_rdata;

  logic        s1_valid;
  logic        s1_direct;
  logic        s1_clear;
  logic [15:0] s1_word;
  logic        s2_ready;

  logic        out_valid;
  rgba_beat_t  out_data;
  rgba_beat_t  out_next;
  logic [15:0] color;

  // Input decode. A write lands in the RAM at its accepting edge, so a pixel
  // accepted at any later edge reads the new value without forwarding.
  always_comb begin
    in_range   = (32'(pixels.data.palette_select) < 32'(PALETTE_SLOTS)) &&
                 (32'(pixels.data.pixel_index) < 32'(PALETTE_ENTRIES));
    is_write   = (pixels.data.kind == KIND_WRITE);
    is_indexed = (pixels.data.kind == KIND_INDEXED);
    is_direct  = (pixels.data.kind == KIND_DIRECT);
    accept     = pixels.valid && pixels.ready;
    has_result = is_direct || (is_indexed && in_range);
    ent_we     = accept && is_write && in_range;
    base_we    = ent_we && (pixels.data.pixel_index == 8'd0);
    rd_en      = accept && is_indexed && in_range;
    ent_addr   = AW'(32'(pixels.data.palette_select) * 32'(PALETTE_ENTRIES) +
                     32'(pixels.data.pixel_index));
    slot_addr  = SLOT_W'(pixels.data.palette_select);
  end

  prgb_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_addr),
    .wdata (pixels.data.color_word),
    .re    (rd_en),
    .raddr (ent_addr),
    .rdata (ent_rdata)
  );

  // Copy of entry 0 of every palette, read alongside the addressed entry.
  prgb_ram #(.WIDTH(16), .DEPTH(PALETTE_SLOTS)) u_base_ram (
    .clk   (clk),
    .we    (base_we),
    .waddr (slot_addr),
    .wdata (pixels.data.color_word),
    .re    (rd_en),
    .raddr (slot_addr),
    .rdata (base_rdata)
  );

  assign s2_ready     = !out_valid || rgba.ready;
  assign pixels.ready = !s1_valid || s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      colorkey_mask <= '0;
    end else if (cfg_we) begin
      colorkey_mask <= cfg_wdata;
    end
  end

  // Read stage: RAM data arrives with the item's side information.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixels.ready) begin
      s1_valid <= accept && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_direct <= is_direct;
      s1_word   <= pixels.data.color_word;
      if (is_direct) begin
        s1_clear <= (pixels.data.color_word == 16'd0);
      end else begin
        s1_clear <= colorkey_mask[pixels.data.palette_select] &&
                    (pixels.data.pixel_index == 8'd0);
      end
    end
  end

  // Expansion into the output register.
  always_comb begin
    color = (ent_rdata == 16'd0) ? base_rdata : ent_rdata;
    if (s1_direct) begin
      out_next.red   = EXP5_TAB[s1_word[15:11]];
      out_next.green = EXP6_TAB[s1_word[10:5]];
      out_next.blue  = EXP5_TAB[s1_word[4:0]];
    end else begin
      out_next.red   = EXP5_TAB[color[4:0]];
      out_next.green = EXP5_TAB[color[9:5]];
      out_next.blue  = EXP5_TAB[color[14:10]];
    end
    out_next.alpha = s1_clear ? ALPHA_CLEAR : ALPHA_OPAQUE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      out_data <= out_next;
    end
  end

  assign rgba.valid = out_valid;
  assign rgba.data  = out_data;

  // A pixel with a result occupies the read stage in the next cycle.
  a_enter_s1: assert property (@(posedge clk) disable iff (rst)
    (accept && has_result) |=> s1_valid)
    else $error("accepted pixel did not reach the read stage");

  // A new output beat comes only from an item held in the read stage.
  a_out_from_s1: assert property (@(posedge clk) disable iff (rst)
    (rgba.valid && !$past(rgba.valid)) |-> $past(s1_valid))
    else $error("output beat appeared without a source item");

  // With both stages full and the receiver stalled, no input is taken.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (rgba.valid && !rgba.ready && s1_valid) |-> !pixels.ready)
    else $error("input accepted while pipeline is full and stalled");

  // A stalled output beat keeps its place until taken.
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (rgba.valid && !rgba.ready) |=> (rgba.valid && $stable(rgba.data)))
    else $error("stalled output beat changed");

endmodule

>>> hdl/prgb_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing.
module prgb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
